FILE: rtl/core/bpc_pkg.sv
// Shared types, constants and the CRC-32 byte step for the beam packet checker.
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 4096;

  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES   = 32'hFFFF_FFFF;
  localparam int unsigned HDR_BYTES  = 12;
  localparam int unsigned SKIP_BYTES = 4;
  localparam logic [15:0] NAK_VALUE  = 16'h00FF;
  localparam logic [15:0] BANK_RESET = 16'd1;

  // Header word slots (word 0 is the tag and is dropped)
  localparam int unsigned HDR_TYPE  = 1;
  localparam int unsigned HDR_LEN   = 2;
  localparam int unsigned HDR_TOTAL = 3;
  localparam int unsigned HDR_BANK  = 4;
  localparam int unsigned HDR_INDEX = 5;

  // APB register map
  localparam logic REG_EXPECTED_BANK = 1'b0;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_LENGTH = 3'd1,
    ST_INDEX  = 3'd2,
    ST_BANK   = 3'd3,
    ST_CRC    = 3'd4
  } status_e;

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc32_byte(logic [31:0] crc_in, logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/bpc_byte_if.sv
// Byte channel: one packet byte per beat plus end-of-packet flag.
`timescale 1ns / 1ps

interface bpc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/core/bpc_ack_if.sv
// Ack channel: one result beat per packet.
`timescale 1ns / 1ps

interface bpc_ack_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] frame_type;
  logic [15:0] ack_value;

  modport source (output valid, output status, output frame_type, output ack_value,
                  input ready);
  modport sink   (input valid, input status, input frame_type, input ack_value,
                  output ready);
endinterface

FILE: rtl/core/beam_packet_checker_crc32_core.sv
// Beam packet checker top level: header parse, CRC-32 over payload, one ack per packet.
// Path: a byte accepted into the input register is processed from there; the ack of a
//   packet is valid in the cycle after its last byte is processed.
// Throughput: one byte per cycle; the byte-wide CRC step and checks sit between
//   the input register and the ack register. Only a last byte waits on a stalled ack.
// Reset (rst_ni low, async): pipeline empty, CRCs all ones, expected_bank = 1.
`timescale 1ns / 1ps

module beam_packet_checker_crc32_core #(
  parameter int unsigned MAX_PACKET_BYTES = bpc_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bpc_byte_if.sink          byte_i,
  bpc_ack_if.source         ack_o,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  import bpc_pkg::*;

  // Byte counter must hold the limit itself
  localparam int unsigned CW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PACKET_BYTES);
  localparam logic [CW-1:0] HDR_CNT = CW'(HDR_BYTES);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [15:0] exp_bank_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_EXPECTED_BANK);
  assign prdata = (paddr[2] == REG_EXPECTED_BANK) ? {16'd0, exp_bank_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_bank_q <= BANK_RESET;
    end else if (cfg_wr) begin
      exp_bank_q <= pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_vld_q;
  logic       out_free;
  logic       proc;      // byte in the input register is consumed this cycle
  logic       in_take;

  // Ack register is free if empty or being drained
  assign out_free = !out_vld_q || ack_o.ready;
  // Non-last bytes never wait on the ack side
  assign proc     = in_vld_q && (!in_last_q || out_free);
  assign byte_i.ready = !in_vld_q || proc;
  assign in_take  = byte_i.valid && byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= byte_i.data_byte;
      in_last_q <= byte_i.last_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Packet state
  // ---------------------------------------------------------------------------
  logic [CW-1:0] cnt_q, cnt_n;
  logic [15:0]   hdr_q [HDR_TYPE:HDR_INDEX];
  logic [15:0]   hdr_n [HDR_TYPE:HDR_INDEX];
  logic          too_long_q, too_long_n;
  logic [31:0]   work_crc_q, work_crc_n;
  logic [31:0]   beam_crc_q, beam_crc_n;
  logic [31:0]   tail_q, tail_n;

  logic          over;
  logic [17:0]   pos_w, end_w, start_w;
  logic [31:0]   crc_base;
  logic [CW-2:0] half;
  logic [31:0]   rx_crc;
  status_e       status;

  always_comb begin
    over       = (cnt_q >= MAX_CNT);
    too_long_n = too_long_q | over;
    cnt_n      = cnt_q;
    hdr_n      = hdr_q;
    work_crc_n = work_crc_q;
    tail_n     = tail_q;
    crc_base   = work_crc_q;
    pos_w      = 18'(cnt_q);
    // Payload window uses the header as it stood before this byte
    end_w      = 18'(HDR_BYTES) + {1'b0, hdr_q[HDR_LEN], 1'b0};
    start_w    = (hdr_q[HDR_INDEX] == 16'd1) ? 18'(HDR_BYTES) : 18'(HDR_BYTES + SKIP_BYTES);

    if (!over) begin
      // Header bytes land in their word lane, little endian
      for (int w = HDR_TYPE; w <= HDR_INDEX; w++) begin
        if (cnt_q < HDR_CNT && 32'(cnt_q[3:1]) == w) begin
          if (cnt_q[0]) begin
            hdr_n[w][15:8] = in_byte_q;
          end else begin
            hdr_n[w][7:0] = in_byte_q;
          end
        end
      end
      // First payload byte seeds the CRC: fresh on pack 1, else continue the beam
      if (cnt_q == HDR_CNT) begin
        crc_base = (hdr_q[HDR_INDEX] == 16'd1) ? CRC_ONES : beam_crc_q;
      end
      work_crc_n = crc_base;
      if (pos_w >= start_w && pos_w < end_w) begin
        work_crc_n = crc32_byte(crc_base, in_byte_q);
      end
      tail_n = {tail_q[23:0], in_byte_q};
      cnt_n  = cnt_q + CW'(1);
    end

    // End-of-packet checks
    half   = cnt_n[CW-1:1];
    rx_crc = {tail_n[23:16], tail_n[31:24], tail_n[7:0], tail_n[15:8]};
    beam_crc_n = beam_crc_q;

    priority if (too_long_n || half < (CW-1)'(HDR_BYTES) ||
                 17'(hdr_n[HDR_LEN]) + 17'(HDR_BYTES) != 17'(half)) begin
      status = ST_LENGTH;
    end else if (hdr_n[HDR_INDEX] == 16'd0 || hdr_n[HDR_INDEX] > hdr_n[HDR_TOTAL]) begin
      status = ST_INDEX;
    end else if (hdr_n[HDR_BANK] != exp_bank_q) begin
      status = ST_BANK;
    end else if (hdr_n[HDR_INDEX] == hdr_n[HDR_TOTAL]) begin
      // Last pack of the beam: final inversion, compare against the trailer
      if (in_last_q) begin
        work_crc_n = work_crc_n ^ CRC_ONES;
      end
      status = (rx_crc == work_crc_n) ? ST_OK : ST_CRC;
    end else begin
      status = ST_OK;
    end

    if (in_last_q && status == ST_OK) begin
      beam_crc_n = work_crc_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      too_long_q <= 1'b0;
      work_crc_q <= CRC_ONES;
      beam_crc_q <= CRC_ONES;
      tail_q     <= '0;
      for (int w = HDR_TYPE; w <= HDR_INDEX; w++) begin
        hdr_q[w] <= '0;
      end
    end else if (proc) begin
      work_crc_q <= work_crc_n;
      beam_crc_q <= beam_crc_n;
      tail_q     <= tail_n;
      if (in_last_q) begin
        // Packet done: drop the header and count
        cnt_q      <= '0;
        too_long_q <= 1'b0;
        for (int w = HDR_TYPE; w <= HDR_INDEX; w++) begin
          hdr_q[w] <= '0;
        end
      end else begin
        cnt_q      <= cnt_n;
        too_long_q <= too_long_n;
        hdr_q      <= hdr_n;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Ack register
  // ---------------------------------------------------------------------------
  logic [2:0]  out_status_q;
  logic [15:0] out_type_q;
  logic [15:0] out_ack_q;
  logic        ack_load;

  assign ack_load = proc && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= ack_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack_load) begin
      out_status_q <= status;
      out_type_q   <= hdr_n[HDR_TYPE];
      out_ack_q    <= (status == ST_OK) ? hdr_n[HDR_INDEX] : NAK_VALUE;
    end
  end

  assign ack_o.valid      = out_vld_q;
  assign ack_o.status     = out_status_q;
  assign ack_o.frame_type = out_type_q;
  assign ack_o.ack_value  = out_ack_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !byte_i.ready |-> (in_vld_q && in_last_q && out_vld_q && !ack_o.ready))
    else $error("input stalled without a blocked last beat");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_CNT)
    else $error("byte counter past packet limit");

  a_ack_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack_load |=> ack_o.valid)
    else $error("last beat processed but no ack beat");

  a_nak_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ack_o.valid && ack_o.status != ST_OK) |-> (ack_o.ack_value == NAK_VALUE))
    else $error("failed packet ack without NAK value");

  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack_load |=> (cnt_q == '0 && !too_long_q))
    else $error("packet state not cleared at packet end");

endmodule

FILE: bench/bpc_ack_checker.sv
// Ack predictor and scoreboard for the beam packet checker.
`timescale 1ns / 1ps

module bpc_ack_checker #(
  parameter int unsigned MAX_PACKET_BYTES = bpc_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpc_byte_if         byte_i,
  bpc_ack_if          ack_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned mismatch_o,
  output int unsigned outstanding_o,
  output int unsigned acks_seen_o
);
  import bpc_pkg::*;

  localparam logic [2:0] BANK_ADDR = 3'(4 * REG_EXPECTED_BANK);

  typedef struct packed {
    status_e     status;
    logic [15:0] frame_type;
    logic [15:0] ack_value;
  } ack_beat_t;

  ack_beat_t   ack_expect_q[$];
  logic [15:0] bank_reg;
  logic [15:0] rx_count;
  logic [15:0] f_type, f_words, f_total, f_bank, f_index;
  logic [31:0] run_crc, beam_crc, tail_word;
  bit          overflow;
  int unsigned errors = 0;
  int unsigned acks_seen = 0;

  // header words are rebuilt per packet
  function automatic void drop_packet();
    rx_count = '0;
    f_type   = '0;
    f_words  = '0;
    f_total  = '0;
    f_bank   = '0;
    f_index  = '0;
    overflow = 1'b0;
  endfunction

  task automatic flag_field(input string name, input logic [15:0] want_v,
                            input logic [15:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: ack %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int unsigned half, first_crc, end_crc;
    status_e     st;
    logic [31:0] rx_crc;
    ack_beat_t   want;
    if (!rst_ni) begin
      bank_reg  = BANK_RESET;
      drop_packet();
      run_crc   = CRC_ONES;
      beam_crc  = CRC_ONES;
      tail_word = '0;
      ack_expect_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == BANK_ADDR) begin
        bank_reg = pwdata[15:0];
      end

      if (byte_i.valid && byte_i.ready) begin
        if (rx_count >= 16'(MAX_PACKET_BYTES)) begin
          overflow = 1'b1;
        end else begin
          if (rx_count < HDR_BYTES) begin
            case (int'(rx_count >> 1))
              HDR_TYPE:  f_type[8*rx_count[0] +: 8]  = byte_i.data_byte;
              HDR_LEN:   f_words[8*rx_count[0] +: 8] = byte_i.data_byte;
              HDR_TOTAL: f_total[8*rx_count[0] +: 8] = byte_i.data_byte;
              HDR_BANK:  f_bank[8*rx_count[0] +: 8]  = byte_i.data_byte;
              HDR_INDEX: f_index[8*rx_count[0] +: 8] = byte_i.data_byte;
              default: ;
            endcase
          end
          // later packs continue the beam and skip the leading payload word pair
          first_crc = HDR_BYTES + ((f_index == 16'd1) ? 0 : SKIP_BYTES);
          end_crc   = HDR_BYTES + 2 * f_words;
          if (rx_count == HDR_BYTES) begin
            run_crc = (f_index == 16'd1) ? CRC_ONES : beam_crc;
          end
          if (rx_count >= first_crc && rx_count < end_crc) begin
            run_crc ^= {24'd0, byte_i.data_byte};
            repeat (8) run_crc = run_crc[0] ? ((run_crc >> 1) ^ CRC_POLY) : (run_crc >> 1);
          end
          tail_word = {tail_word[23:0], byte_i.data_byte};
          rx_count++;
        end

        if (byte_i.last_byte) begin
          half = rx_count >> 1;
          if (overflow || half < HDR_BYTES || f_words != half - HDR_BYTES) begin
            st = ST_LENGTH;
          end else if (f_index == 16'd0 || f_index > f_total) begin
            st = ST_INDEX;
          end else if (f_bank != bank_reg) begin
            st = ST_BANK;
          end else if (f_index == f_total) begin
            rx_crc  = {tail_word[23:16], tail_word[31:24], tail_word[7:0], tail_word[15:8]};
            run_crc ^= CRC_ONES;
            st = (rx_crc == run_crc) ? ST_OK : ST_CRC;
          end else begin
            st = ST_OK;
          end
          if (st == ST_OK) beam_crc = run_crc;
          want.status     = st;
          want.frame_type = f_type;
          want.ack_value  = (st == ST_OK) ? f_index : NAK_VALUE;
          ack_expect_q.push_back(want);
          drop_packet();
        end
      end

      if (ack_i.valid && ack_i.ready) begin
        acks_seen++;
        if (ack_expect_q.size() == 0) begin
          errors++;
          $display("%0t: ack beat with no packet pending, expected none, got %0d/%h/%h",
                   $time, ack_i.status, ack_i.frame_type, ack_i.ack_value);
        end else begin
          want = ack_expect_q.pop_front();
          flag_field("status", 16'(want.status), 16'(ack_i.status));
          flag_field("frame_type", want.frame_type, ack_i.frame_type);
          flag_field("ack_value", want.ack_value, ack_i.ack_value);
        end
      end
    end
    outstanding_o <= ack_expect_q.size();
    mismatch_o    <= errors;
    acks_seen_o   <= acks_seen;
  end

endmodule

FILE: bench/tb_top.sv
// Testbench top: clock, reset, bank setup and packet traffic for the beam packet checker.
`timescale 1ns / 1ps

module tb_top;
  import bpc_pkg::*;

  localparam int unsigned MAX_BYTES       = MAX_PACKET_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int unsigned BYTES_PER_PHASE = 600;   // small packets, per bank setting
  localparam int unsigned LONG_HOLD       = 600;   // ack stall length in cycles
  localparam int unsigned HOLD_AT_ACK     = 30;    // ack count that starts the stall
  localparam int unsigned DRAIN_CYCLES    = 4;     // idle clocks once no ack is outstanding
  localparam logic [2:0]  BANK_ADDR       = 3'(4 * REG_EXPECTED_BANK);

  // ways a beam pack gets damaged on purpose
  typedef enum logic [2:0] {
    DMG_LENGTH,
    DMG_INDEX,
    DMG_BANK,
    DMG_CRC,
    DMG_TRUNCATE
  } damage_e;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bpc_byte_if byte_if ();
  bpc_ack_if  ack_if ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned acks_checked;

  // stimulus-side mirror of the beam: lets well-formed last packs carry a good CRC
  logic [7:0]  pkt[$];
  logic [15:0] bank_now;
  logic [15:0] beam_total;
  logic [15:0] beam_next;
  logic [31:0] beam_crc_mirror;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned bytes_sent;
  int unsigned total_bytes  = 0;
  int unsigned total_packs  = 0;
  int unsigned good_packs   = 0;
  int unsigned bad_packs    = 0;
  int unsigned junk_packs   = 0;
  int unsigned cycle_count  = 0;

  beam_packet_checker_crc32_core #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_if),
    .ack_o   (ack_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bpc_ack_checker #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_i        (byte_if),
    .ack_i         (ack_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatch_o    (mismatches),
    .outstanding_o (outstanding),
    .acks_seen_o   (acks_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Ack receiver: random back-pressure, plus one long hold-off once enough acks
  // went by. The sender keeps pushing bytes meanwhile, so the ack register fills
  // and the block has to stall a last byte.
  initial begin : ack_receiver
    int unsigned taken;
    int unsigned hold_left;
    bit          held;
    taken     = 0;
    hold_left = 0;
    held      = 1'b0;
    ack_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (ack_if.valid && ack_if.ready) taken++;
      if (!held && taken >= HOLD_AT_ACK) begin
        held      = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        ack_if.ready <= 1'b0;
        hold_left--;
      end else begin
        ack_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Bytes of pkt go out one beat each; valid stays high across back-to-back beats.
  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) begin
      while ($urandom_range(99) < tx_idle_pct) begin
        byte_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      byte_if.valid     <= 1'b1;
      byte_if.data_byte <= pkt[i];
      byte_if.last_byte <= (i == pkt.size() - 1);
      do @(posedge clk_i); while (!byte_if.ready);
    end
    total_bytes += pkt.size();
    total_packs++;
  endtask

  // Header + random payload + trailer. crc returns what a passing pack would commit;
  // for the last pack of a beam the trailer is sealed with the inverted CRC.
  task automatic build_pack(input logic [15:0] idx, input logic [15:0] total,
                            input logic [15:0] bank, input int unsigned words,
                            input int unsigned tail_len, output logic [31:0] crc);
    logic [15:0] hdr[6];
    int unsigned n;
    hdr = '{16'($urandom), 16'($urandom), 16'(words), total, bank, idx};
    pkt.delete();
    foreach (hdr[w]) begin
      pkt.push_back(hdr[w][7:0]);
      pkt.push_back(hdr[w][15:8]);
    end
    crc = (idx == 16'd1) ? CRC_ONES : beam_crc_mirror;
    for (int i = 0; i < 2 * words; i++) begin
      pkt.push_back(8'($urandom));
      if (idx == 16'd1 || i >= SKIP_BYTES) begin
        crc ^= {24'd0, pkt[pkt.size() - 1]};
        repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    repeat (tail_len) pkt.push_back(8'($urandom));
    n = pkt.size();
    if (idx == total) begin
      crc ^= CRC_ONES;
      // trailer word order is byte-swapped within each half
      pkt[n - 4] = crc[23:16];
      pkt[n - 3] = crc[31:24];
      pkt[n - 2] = crc[7:0];
      pkt[n - 1] = crc[15:8];
    end
  endtask

  // Mostly in-order beam packs; some damaged packs and some raw junk.
  task automatic random_packet();
    int unsigned roll, words, tail_len, cut, n;
    logic [31:0] c;
    logic [15:0] idx, bank;
    damage_e     dmg;
    roll     = $urandom_range(99);
    words    = ($urandom_range(7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
    tail_len = HDR_BYTES + $urandom_range(1);
    if (beam_next > beam_total || beam_next > 16'd6 || $urandom_range(19) == 0) begin
      beam_total = ($urandom_range(9) == 0) ? 16'($urandom_range(5, 65535))
                                            : 16'($urandom_range(1, 4));
      beam_next  = 16'd1;
    end
    if (roll < 70) begin
      build_pack(beam_next, beam_total, bank_now, words, tail_len, c);
      beam_crc_mirror = c;
      beam_next++;
      good_packs++;
    end else if (roll < 85) begin
      // a damaged pack never commits, so the mirror stays in step
      idx  = beam_next;
      bank = bank_now;
      dmg  = damage_e'($urandom_range(DMG_TRUNCATE));
      if (dmg == DMG_INDEX) begin
        idx = (beam_total == 16'hFFFF || $urandom_range(1)) ? 16'd0 : beam_total + 16'd1;
      end
      if (dmg == DMG_BANK) bank = bank_now ^ (16'd1 << $urandom_range(15));
      if (dmg == DMG_CRC) idx = beam_total;
      build_pack(idx, beam_total, bank, words, tail_len, c);
      case (dmg)
        DMG_LENGTH: pkt[4] ^= 8'd1 << $urandom_range(7);
        DMG_CRC: pkt[pkt.size() - 1 - $urandom_range(3)] ^= 8'd1 << $urandom_range(7);
        DMG_TRUNCATE: begin
          cut = $urandom_range(1, 2 * HDR_BYTES - 1);
          while (pkt.size() > cut) void'(pkt.pop_back());
        end
        default: ;
      endcase
      bad_packs++;
    end else begin
      // junk bytes; the length word is nudged off if it happens to fit
      n = $urandom_range(1, 48);
      pkt.delete();
      repeat (n) pkt.push_back(8'($urandom));
      if (n >= 2 * HDR_BYTES && {pkt[5], pkt[4]} == 16'(n / 2 - HDR_BYTES)) pkt[4] ^= 8'd1;
      junk_packs++;
    end
    bytes_sent += pkt.size();
    send_packet();
  endtask

  // Let every expected ack come back, then let the pipeline idle for the drain period.
  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Two-phase APB write; upper data bits are junk the register must drop.
  task automatic write_bank(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BANK_ADDR;
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    bank_now = value;
  endtask

  initial begin : stimulus
    logic [31:0] c;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = 8'd0;
    byte_if.last_byte = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    bank_now          = BANK_RESET;
    beam_total        = 16'd0;
    beam_next         = 16'd1;
    beam_crc_mirror   = CRC_ONES;
    tx_idle_pct       = 13;
    rx_idle_pct       = 82;
    rst_ni            = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset bank value: a one-byte packet (short, header all zero),
    // then a minimal single-pack beam with an all-ones type and empty payload.
    pkt.delete();
    pkt.push_back(8'($urandom));
    send_packet();
    build_pack(16'd1, 16'd1, bank_now, 0, HDR_BYTES, c);
    pkt[2] = 8'hFF;
    pkt[3] = 8'hFF;
    beam_crc_mirror = c;
    send_packet();

    // Three bank settings: all ones, zero, random. Idling flips between sides,
    // then goes away for the last phase.
    for (int p = 0; p < 3; p++) begin
      wait_drained();
      write_bank((p == 0) ? 16'hFFFF : (p == 1) ? 16'h0000 : 16'($urandom));
      tx_idle_pct = (p == 0) ? 13 : (p == 1) ? 82 : 0;
      rx_idle_pct <= (p == 0) ? 82 : (p == 1) ? 13 : 0;
      bytes_sent = 0;
      while (bytes_sent < BYTES_PER_PHASE) random_packet();
    end
    wait_drained();

    $display("summary: %0d packets in %0d bytes: %0d beam packs, %0d damaged, %0d junk",
             total_packs, total_bytes, good_packs, bad_packs, junk_packs);
    $display("summary: %0d acks checked over four bank values, one %0d-cycle ack stall",
             acks_checked, LONG_HOLD);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
